// ===== rtl/u8d_pkg.sv =====
package u8d_pkg;

    // field widths
    localparam int BYTE_W  = 8;
    localparam int CP_W    = 21;
    localparam int HOLD_N  = 3;
    localparam int SLOT_N  = 5;
    localparam int SLOT_W  = 3;
    localparam int LEN_W   = 3;
    localparam int CNT_W   = 2;

    // queue sizing
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // byte classification constants
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_TAG   = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_TAG  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_TAG  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_TAG  = 8'hF0;

    localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
    localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_UTF8_MODE   = 1'b0,
        REG_APPEND_TERM = 1'b1
    } cfg_reg_t;

    // one queue entry: all code points caused by one input word
    typedef struct packed {
        logic [SLOT_W-1:0]          count;
        logic                       eos;
        logic [SLOT_N-1:0][CP_W-1:0] cps;
    } u8d_entry_t;

    // sequence length announced by a lead byte, zero when it is not a lead
    function automatic logic [LEN_W-1:0] lead_len(input logic [BYTE_W-1:0] b);
        logic [LEN_W-1:0] len;
        len = LEN_NONE;
        if ((b & LEAD2_MASK) == LEAD2_TAG) begin
            len = LEN_TWO;
        end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
            len = LEN_THREE;
        end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
            len = LEN_FOUR;
        end
        return len;
    endfunction

    function automatic logic [CP_W-1:0] byte_cp(input logic [BYTE_W-1:0] b);
        return {{(CP_W-BYTE_W){1'b0}}, b};
    endfunction

endpackage

// ===== rtl/u8d_front.sv =====
module u8d_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic                        cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [u8d_pkg::BYTE_W-1:0]  s_in_byte,
    input  logic                        s_end_of_string,
    input  logic                        q_ready,
    output logic                        q_valid,
    output u8d_pkg::u8d_entry_t         q_entry
);
    import u8d_pkg::*;

    logic                    utf8_mode_reg;
    logic                    append_term_reg;
    logic [BYTE_W-1:0]       held_reg [HOLD_N];
    logic [BYTE_W-1:0]       held_next [HOLD_N];
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [LEN_W-1:0]        len_reg, len_next;
    logic [SLOT_N-1:0][CP_W-1:0] cps;
    logic [SLOT_W-1:0]       n;
    logic [LEN_W-1:0]        cls;
    logic                    do_start;
    logic                    is_cont;
    logic [CP_W-1:0]         joined;
    logic                    accept;

    assign s_ready = q_ready;
    assign accept  = s_valid && q_ready;
    assign cls     = lead_len(s_in_byte);
    assign is_cont = (s_in_byte & CONT_MASK) == CONT_TAG;

    // assemble the code point of a completed sequence
    always_comb begin
        if (len_reg == LEN_TWO) begin
            joined = {10'b0, held_reg[0][4:0], s_in_byte[5:0]};
        end else if (len_reg == LEN_THREE) begin
            joined = {5'b0, held_reg[0][3:0], held_reg[1][5:0], s_in_byte[5:0]};
        end else begin
            joined = {held_reg[0][2:0], held_reg[1][5:0], held_reg[2][5:0],
                      s_in_byte[5:0]};
        end
    end

    // classify the word and list the code points it releases
    always_comb begin
        cps       = '0;
        n         = '0;
        held_next = held_reg;
        cnt_next  = cnt_reg;
        len_next  = len_reg;
        do_start  = 1'b0;
        if (utf8_mode_reg) begin
            if (cnt_reg == '0) begin
                do_start = 1'b1;
            end else if (!is_cont) begin
                for (int i = 0; i < HOLD_N; i++) begin
                    if (CNT_W'(i) < cnt_reg) begin
                        cps[n] = byte_cp(held_reg[i]);
                        n      = n + SLOT_W'(1);
                    end
                end
                cnt_next = '0;
                len_next = LEN_NONE;
                do_start = 1'b1;
            end else if (({1'b0, cnt_reg} + LEN_W'(1)) < len_reg) begin
                held_next[cnt_reg] = s_in_byte;
                cnt_next = cnt_reg + CNT_W'(1);
            end else begin
                cps[n]   = joined;
                n        = n + SLOT_W'(1);
                cnt_next = '0;
                len_next = LEN_NONE;
            end
            if (do_start) begin
                if (cls == LEN_NONE) begin
                    cps[n] = byte_cp(s_in_byte);
                    n      = n + SLOT_W'(1);
                end else begin
                    held_next[0] = s_in_byte;
                    cnt_next     = CNT_W'(1);
                    len_next     = cls;
                end
            end
        end else begin
            for (int i = 0; i < HOLD_N; i++) begin
                if (CNT_W'(i) < cnt_reg) begin
                    cps[n] = byte_cp(held_reg[i]);
                    n      = n + SLOT_W'(1);
                end
            end
            cnt_next = '0;
            len_next = LEN_NONE;
            cps[n]   = byte_cp(s_in_byte);
            n        = n + SLOT_W'(1);
        end
        // end of string flushes whatever is still held
        if (s_end_of_string) begin
            for (int i = 0; i < HOLD_N; i++) begin
                if (CNT_W'(i) < cnt_next) begin
                    cps[n] = byte_cp(held_next[i]);
                    n      = n + SLOT_W'(1);
                end
            end
            cnt_next = '0;
            len_next = LEN_NONE;
            if (append_term_reg) begin
                cps[n] = '0;
                n      = n + SLOT_W'(1);
            end
        end
    end

    assign q_valid       = accept && (n != '0);
    assign q_entry.count = n;
    assign q_entry.eos   = s_end_of_string;
    assign q_entry.cps   = cps;

    // configuration and sequence state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            utf8_mode_reg   <= 1'b1;
            append_term_reg <= 1'b0;
            cnt_reg         <= '0;
            len_reg         <= LEN_NONE;
        end else begin
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_index))
                    REG_UTF8_MODE:   utf8_mode_reg   <= cfg_data;
                    REG_APPEND_TERM: append_term_reg <= cfg_data;
                    default:         ;
                endcase
            end
            if (accept) begin
                cnt_reg <= cnt_next;
                len_reg <= len_next;
            end
        end
    end

    // held bytes carry no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            held_reg <= held_next;
        end
    end

endmodule

// ===== rtl/u8d_queue.sv =====
module u8d_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_valid,
    output logic                wr_ready,
    input  u8d_pkg::u8d_entry_t wr_entry,
    output logic                rd_valid,
    input  logic                rd_pop,
    output u8d_pkg::u8d_entry_t rd_entry
);
    import u8d_pkg::*;

    u8d_entry_t           mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg;
    logic                 push;
    logic                 pop;

    assign wr_ready = count_reg != Q_CNT_W'(Q_DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_entry = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + Q_CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - Q_CNT_W'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

// ===== rtl/u8d_back.sv =====
module u8d_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        e_valid,
    input  u8d_pkg::u8d_entry_t         e_entry,
    output logic                        e_pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [u8d_pkg::CP_W-1:0]    m_code_point,
    output logic                        m_run_last,
    output logic                        m_string_done
);
    import u8d_pkg::*;

    logic [SLOT_W-1:0] slot_reg;
    logic              last_slot;
    logic              take;

    assign last_slot     = slot_reg == (e_entry.count - SLOT_W'(1));
    assign take          = e_valid && m_ready;
    assign m_valid       = e_valid;
    assign m_code_point  = e_entry.cps[slot_reg];
    assign m_run_last    = last_slot;
    assign m_string_done = last_slot && e_entry.eos;
    assign e_pop         = take && last_slot;

    // walk the slots of the head entry one word per cycle while m_ready is high
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= '0;
        end else if (take) begin
            if (last_slot) begin
                slot_reg <= '0;
            end else begin
                slot_reg <= slot_reg + SLOT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/utf8_to_code_point_decoder_unit.sv =====
// Streaming UTF-8 to code point decoder with a Latin-1 fallback. One byte word
// is taken per cycle whenever the four-entry result queue has room; each
// accepted byte's code points are queued and show on the output behind earlier
// entries. A byte that releases k code points (0 to 5: a malformed or truncated
// sequence flushes its held bytes, and the optional zero terminator follows the
// last byte) takes k words. The output drains one code point per cycle while
// m_ready is high, so the sustained rate is one byte per cycle as long as bytes
// average at most one code point each, and bursts are soaked up by the queue.
module utf8_to_code_point_decoder_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic                        cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [u8d_pkg::BYTE_W-1:0]  s_in_byte,
    input  logic                        s_end_of_string,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [u8d_pkg::CP_W-1:0]    m_code_point,
    output logic                        m_run_last,
    output logic                        m_string_done
);
    import u8d_pkg::*;

    logic       wr_valid, wr_ready;
    u8d_entry_t wr_entry;
    logic       rd_valid, rd_pop;
    u8d_entry_t rd_entry;

    // byte classification and sequence state
    u8d_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .s_end_of_string (s_end_of_string),
        .q_ready         (wr_ready),
        .q_valid         (wr_valid),
        .q_entry         (wr_entry)
    );

    // result queue
    u8d_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (wr_valid),
        .wr_ready (wr_ready),
        .wr_entry (wr_entry),
        .rd_valid (rd_valid),
        .rd_pop   (rd_pop),
        .rd_entry (rd_entry)
    );

    // code point serializer
    u8d_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .e_valid       (rd_valid),
        .e_entry       (rd_entry),
        .e_pop         (rd_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_code_point  (m_code_point),
        .m_run_last    (m_run_last),
        .m_string_done (m_string_done)
    );

endmodule

// ===== rtl/u8d_checker.sv =====
module u8d_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [u8d_pkg::CP_W-1:0]    m_code_point,
    input logic                        m_run_last,
    input logic                        m_string_done
);
    import u8d_pkg::*;

    // output word holds while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_code_point)
            && $stable(m_run_last) && $stable(m_string_done))
        else $error("output word changed while stalled");

    // end of string is always the last word of its byte
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_string_done |-> m_run_last)
        else $error("string end not on last word of byte");

    // a byte's words follow back to back
    a_run_cont: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_run_last |=> m_valid)
        else $error("gap inside the words of one byte");

    // reset leaves the queue empty and the input open
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("queue not empty after reset");

endmodule

bind utf8_to_code_point_decoder_unit u8d_checker u_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_code_point  (m_code_point),
    .m_run_last    (m_run_last),
    .m_string_done (m_string_done)
);
